// File: rtl/ssot_pkg.sv
// ssot_pkg: shared widths, register codes and reset values for the
// point to segment distance test; no dependencies
`default_nettype none
package ssot_pkg;
   localparam int COORD_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int RADIUS_BITS    = 24;
   localparam int DIST_BITS      = 25;
   localparam int ADDR_BITS      = 1;
   localparam int DATA_BITS      = 32;
   localparam logic [ADDR_BITS-1:0] REG_RADIUS = 1'b0;
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 24'd2560;
endpackage
`default_nettype wire

// File: rtl/ssot_if.sv
// ssot_if: valid/ready word channels for query and result
// depends on ssot_pkg
`default_nettype none
interface ssot_req_if #(parameter int CoordBits = ssot_pkg::COORD_BITS_DEF);
   logic valid;
   logic ready;
   logic signed [CoordBits-1:0] point_x, point_y, point_z;
   logic signed [CoordBits-1:0] seg_start_x, seg_start_y, seg_start_z;
   logic signed [CoordBits-1:0] seg_end_x, seg_end_y, seg_end_z;
   modport source (output valid, point_x, point_y, point_z, seg_start_x, seg_start_y,
                   seg_start_z, seg_end_x, seg_end_y, seg_end_z, input ready);
   modport sink (input valid, point_x, point_y, point_z, seg_start_x, seg_start_y,
                 seg_start_z, seg_end_x, seg_end_y, seg_end_z, output ready);
endinterface

interface ssot_rsp_if;
   logic valid;
   logic ready;
   logic [ssot_pkg::DIST_BITS-1:0] distance;
   logic blocked;
   modport source (output valid, distance, blocked, input ready);
   modport sink (input valid, distance, blocked, output ready);
endinterface
`default_nettype wire

// File: rtl/ssot_divsqrt.sv
// ssot_divsqrt: pipelined restoring divider (one quotient bit per stage)
// followed by pipelined floor square root; depends on ssot_pkg
`default_nettype none
module ssot_divsqrt #(
   parameter int NumBits = 96,
   parameter int DenBits = 50,
   parameter int SqBits  = 50,
   parameter int DistBits = 25
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic enable,
   input  wire logic in_valid,
   input  wire logic [NumBits-1:0] in_num,
   input  wire logic [DenBits-1:0] in_den,
   input  wire logic [SqBits-1:0] in_ww,
   input  wire logic in_use_div,
   input  wire logic [SqBits-1:0] in_r2,
   output logic out_valid,
   output logic [DistBits-1:0] out_dist,
   output logic out_blocked
);
   localparam int QBits = SqBits + 1;
   localparam int RtBits = (SqBits + 1) / 2;
   localparam int Nd = QBits;
   localparam int Ns = RtBits;
   localparam int RemBits = DenBits + 1;

   // divider stages
   logic [Nd:0] dv_ff;
   logic [NumBits-1:0] dn_ff [Nd+1];
   logic [RemBits-1:0] dr_ff [Nd+1];
   logic [QBits-1:0] dq_ff [Nd+1];
   logic [DenBits-1:0] dd_ff [Nd+1];
   logic [SqBits-1:0] dw_ff [Nd+1];
   logic [SqBits-1:0] dr2_ff [Nd+1];
   logic [Nd:0] du_ff;

   // quotient bits above QBits are known zero since q < ww
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (enable) begin
         dv_ff <= {dv_ff[Nd-1:0], in_valid};
      end
   end

   // numerator bits above QBits start as the partial remainder
   always_ff @(posedge clock) begin
      if (enable) begin
         dn_ff[0] <= in_num << (NumBits - QBits);
         dr_ff[0] <= RemBits'(in_num >> QBits);
         dq_ff[0] <= '0;
         dd_ff[0] <= in_den;
         dw_ff[0] <= in_ww;
         dr2_ff[0] <= in_r2;
         du_ff[0] <= in_use_div;
      end
   end

   for (genvar i = 0; i < Nd; i++) begin : g_div
      logic [RemBits:0] sh_in;
      logic ge_in;
      always_comb begin
         sh_in = {dr_ff[i], dn_ff[i][NumBits-1]};
         ge_in = sh_in >= {2'b00, dd_ff[i]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            dn_ff[i+1] <= dn_ff[i] << 1;
            dr_ff[i+1] <= ge_in ? RemBits'(sh_in - {2'b00, dd_ff[i]}) : RemBits'(sh_in);
            dq_ff[i+1] <= {dq_ff[i][QBits-2:0], ge_in};
            dd_ff[i+1] <= dd_ff[i];
            dw_ff[i+1] <= dw_ff[i];
            dr2_ff[i+1] <= dr2_ff[i];
            du_ff[i+1] <= du_ff[i];
         end
      end
   end

   // subtract the quotient from ww when the divide is used, clamped at zero
   logic [SqBits-1:0] d2_in;
   logic [QBits-1:0] q_in;
   always_comb begin
      q_in = dq_ff[Nd];
      if (!du_ff[Nd]) d2_in = dw_ff[Nd];
      else if (q_in <= {1'b0, dw_ff[Nd]}) d2_in = SqBits'({1'b0, dw_ff[Nd]} - q_in);
      else d2_in = '0;
   end

   // square root stages, two radicand bits per stage
   localparam int RadBits = 2 * Ns;
   logic [Ns:0] sv_ff;
   logic [RadBits-1:0] sn_ff [Ns+1];
   logic [Ns+1:0] sr_ff [Ns+1];
   logic [Ns-1:0] sq_ff [Ns+1];
   logic [Ns:0] sb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0;
      end else if (enable) begin
         sv_ff <= {sv_ff[Ns-1:0], dv_ff[Nd]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sn_ff[0] <= RadBits'(d2_in);
         sr_ff[0] <= '0;
         sq_ff[0] <= '0;
         sb_ff[0] <= d2_in <= dr2_ff[Nd];
      end
   end

   for (genvar j = 0; j < Ns; j++) begin : g_sqrt
      logic [Ns+1:0] rs_in, tr_in;
      logic ok_in;
      always_comb begin
         rs_in = {sr_ff[j][Ns-1:0], sn_ff[j][RadBits-1 -: 2]};
         tr_in = {sq_ff[j], 2'b01};
         ok_in = rs_in >= tr_in;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            sn_ff[j+1] <= sn_ff[j] << 2;
            sr_ff[j+1] <= ok_in ? rs_in - tr_in : rs_in;
            sq_ff[j+1] <= {sq_ff[j][Ns-2:0], ok_in};
            sb_ff[j+1] <= sb_ff[j];
         end
      end
   end

   always_comb begin
      out_valid = sv_ff[Ns];
      out_blocked = sb_ff[Ns];
      if (Ns > DistBits && |(sq_ff[Ns] >> DistBits)) out_dist = '1;
      else out_dist = DistBits'(sq_ff[Ns]);
   end
endmodule
`default_nettype wire

// File: rtl/segment_sphere_occlusion_test.sv
// segment_sphere_occlusion_test: top level with csr port, dot product
// pipeline and output buffer; depends on ssot_pkg, ssot_if, ssot_divsqrt
// One query per cycle while the result side keeps up. From acceptance to result a
// query passes 6 stages of vector math, 2*COORD_BITS+6 divider stages (an input
// register and one per quotient bit), COORD_BITS+3 square root stages and two
// through the result buffer. Results queue in a buffer of Depth plus eight words;
// req ready drops only when the words in flight and queued fill it.
`default_nettype none
module segment_sphere_occlusion_test #(
   parameter int COORD_BITS = ssot_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   ssot_req_if.sink req,
   ssot_rsp_if.source rsp,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [ssot_pkg::ADDR_BITS-1:0] csr_paddr,
   input  wire logic [ssot_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic [ssot_pkg::DATA_BITS-1:0] csr_prdata,
   output logic csr_pready
);
   localparam int CB = COORD_BITS;
   localparam int DB = CB + 1;
   localparam int PB = 2 * DB;
   localparam int SB = PB + 2;
   localparam int NB = 2 * SB;
   localparam int RB = ssot_pkg::RADIUS_BITS;

   logic [RB-1:0] radius_ff;
   logic [2*RB-1:0] r2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= ssot_pkg::RADIUS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == ssot_pkg::REG_RADIUS) begin
         radius_ff <= csr_pwdata[RB-1:0];
      end
   end
   always_ff @(posedge clock) r2_ff <= radius_ff * radius_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ssot_pkg::REG_RADIUS) ?
                       ssot_pkg::DATA_BITS'(radius_ff) : '0;

   localparam int Depth = 6 + (SB + 1) + (SB + 2) / 2;
   logic enable;
   logic pipe_out_valid;
   assign enable = 1'b1;

   // stage 1: differences
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [DB-1:0] w_ff [3], vv_ff [3], e_ff [3];
   // stage 2: products
   logic signed [PB-1:0] ww_p_ff [3], ll_p_ff [3], wv_p_ff [3], ee_p_ff [3];
   // stage 3: sums
   logic [SB-1:0] ww_ff, ll_ff, ee_ff;
   logic signed [SB-1:0] wv_ff;
   // stage 4: case select
   logic [SB-1:0] ll4_ff, d4_ff;
   logic [PB-1:0] wv4_ff;
   logic sel4_ff;
   // stage 5: partial squares of wv, below 2**PB whenever the divide is used
   logic [PB-1:0] hh5_ff, hl5_ff, lo5_ff;
   logic [SB-1:0] ll5_ff, d5_ff;
   logic sel5_ff;
   logic [NB-1:0] num6_ff;
   logic [SB-1:0] ll6_ff, d6_ff;
   logic sel6_ff;

   logic accept;
   assign accept = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff} <= '0;
      end else begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff} <= {accept, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff};
      end
   end

   always_ff @(posedge clock) begin
      w_ff[0] <= DB'(req.point_x) - DB'(req.seg_start_x);
      w_ff[1] <= DB'(req.point_y) - DB'(req.seg_start_y);
      w_ff[2] <= DB'(req.point_z) - DB'(req.seg_start_z);
      vv_ff[0] <= DB'(req.seg_end_x) - DB'(req.seg_start_x);
      vv_ff[1] <= DB'(req.seg_end_y) - DB'(req.seg_start_y);
      vv_ff[2] <= DB'(req.seg_end_z) - DB'(req.seg_start_z);
      e_ff[0] <= DB'(req.point_x) - DB'(req.seg_end_x);
      e_ff[1] <= DB'(req.point_y) - DB'(req.seg_end_y);
      e_ff[2] <= DB'(req.point_z) - DB'(req.seg_end_z);
      for (int k = 0; k < 3; k++) begin
         ww_p_ff[k] <= w_ff[k] * w_ff[k];
         ll_p_ff[k] <= vv_ff[k] * vv_ff[k];
         wv_p_ff[k] <= w_ff[k] * vv_ff[k];
         ee_p_ff[k] <= e_ff[k] * e_ff[k];
      end
      ww_ff <= SB'(ww_p_ff[0]) + SB'(ww_p_ff[1]) + SB'(ww_p_ff[2]);
      ll_ff <= SB'(ll_p_ff[0]) + SB'(ll_p_ff[1]) + SB'(ll_p_ff[2]);
      ee_ff <= SB'(ee_p_ff[0]) + SB'(ee_p_ff[1]) + SB'(ee_p_ff[2]);
      wv_ff <= SB'(wv_p_ff[0]) + SB'(wv_p_ff[1]) + SB'(wv_p_ff[2]);
      ll4_ff <= ll_ff;
      wv4_ff <= PB'(wv_ff);
      if (ll_ff == '0 || wv_ff <= 0) begin
         sel4_ff <= 1'b0;
         d4_ff <= ww_ff;
      end else if (SB'(wv_ff) >= ll_ff) begin
         sel4_ff <= 1'b0;
         d4_ff <= ee_ff;
      end else begin
         sel4_ff <= 1'b1;
         d4_ff <= ww_ff;
      end
      hh5_ff <= wv4_ff[PB-1:DB] * wv4_ff[PB-1:DB];
      hl5_ff <= wv4_ff[PB-1:DB] * wv4_ff[DB-1:0];
      lo5_ff <= wv4_ff[DB-1:0] * wv4_ff[DB-1:0];
      ll5_ff <= ll4_ff;
      d5_ff <= d4_ff;
      sel5_ff <= sel4_ff;
      num6_ff <= (NB'(hh5_ff) << PB) + (NB'(hl5_ff) << (DB + 1)) + NB'(lo5_ff);
      ll6_ff <= ll5_ff;
      d6_ff <= d5_ff;
      sel6_ff <= sel5_ff;
   end

   logic [ssot_pkg::DIST_BITS-1:0] p_dist;
   logic p_blk;
   logic [SB-1:0] r2_ext;
   assign r2_ext = (SB >= 2*RB) ? SB'(r2_ff) :
                   ((r2_ff >> SB) != 0 ? '1 : SB'(r2_ff));

   ssot_divsqrt #(.NumBits(NB), .DenBits(SB), .SqBits(SB),
                  .DistBits(ssot_pkg::DIST_BITS)) u_divsqrt (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(v6_ff), .in_num(num6_ff), .in_den(ll6_ff | SB'(!sel6_ff)),
      .in_ww(d6_ff), .in_use_div(sel6_ff), .in_r2(r2_ext),
      .out_valid(pipe_out_valid), .out_dist(p_dist), .out_blocked(p_blk));

   // credit count: items in flight plus buffered must fit the output fifo
   localparam int FifoDepth = Depth + 8;
   localparam int FB = $clog2(FifoDepth + 1);
   localparam int AB = $clog2(FifoDepth);
   logic [ssot_pkg::DIST_BITS:0] fifo_mem [FifoDepth];
   logic [ssot_pkg::DIST_BITS:0] word_ff;
   logic word_valid_ff;
   logic [AB-1:0] wp_ff, rp_ff;
   logic [FB-1:0] cnt_all_ff, fill_ff;
   logic pop, load;
   assign pop = rsp.valid && rsp.ready;
   assign load = (fill_ff != '0) && (!word_valid_ff || pop);
   assign req.ready = cnt_all_ff < FB'(FifoDepth);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_all_ff <= '0;
         fill_ff <= '0;
         wp_ff <= '0;
         rp_ff <= '0;
         word_valid_ff <= 1'b0;
      end else begin
         cnt_all_ff <= cnt_all_ff + FB'(accept) - FB'(pop);
         fill_ff <= fill_ff + FB'(pipe_out_valid) - FB'(load);
         if (pipe_out_valid) wp_ff <= (wp_ff == AB'(FifoDepth-1)) ? '0 : wp_ff + 1'b1;
         if (load) rp_ff <= (rp_ff == AB'(FifoDepth-1)) ? '0 : rp_ff + 1'b1;
         if (load) word_valid_ff <= 1'b1;
         else if (pop) word_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (pipe_out_valid) fifo_mem[wp_ff] <= {p_blk, p_dist};
      if (load) word_ff <= fifo_mem[rp_ff];
   end
   assign rsp.valid = word_valid_ff;
   assign {rsp.blocked, rsp.distance} = word_ff;

   a_fill_le_all: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cnt_all_ff) else $error("fifo fill exceeds credits");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_all_ff <= FB'(FifoDepth)) else $error("credit overflow");
   a_v_chain: assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> v2_ff) else $error("valid lost in pipeline");
endmodule
`default_nettype wire
